FILE: sv/eyr_pkg.sv
// Shared types and constants for the Euler YXZ vertex rotation core.
`default_nettype none

package eyr_pkg;

  // Fixed point formats: coordinates Q16.16, trig values Q2.16
  localparam int COORD_W   = 32;
  localparam int TRIG_FRAC = 16;
  localparam int TRIG_W    = TRIG_FRAC + 2;

  // Full product, product after the truncating shift, and sum of two shifted products
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SHIFT_W = PROD_W - TRIG_FRAC;
  localparam int SUM_W   = SHIFT_W + 1;

  // One rotation cell per Euler angle; each cell has a product stage and a sum stage
  localparam int NUM_CELLS = 3;
  localparam int LATENCY   = 2 * NUM_CELLS;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = 3;

  // Register indexes, in byte address order (index * 4)
  typedef enum logic [IDX_W-1:0] {
    REG_SIN_YAW   = 3'd0,
    REG_COS_YAW   = 3'd1,
    REG_SIN_PITCH = 3'd2,
    REG_COS_PITCH = 3'd3,
    REG_SIN_ROLL  = 3'd4,
    REG_COS_ROLL  = 3'd5
  } reg_idx_t;

  // Reset value of a cosine register: 1.0
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) <<< TRIG_FRAC;

  // Sine and cosine of one stage
  typedef struct packed {
    logic signed [TRIG_W-1:0] sn;
    logic signed [TRIG_W-1:0] cs;
  } trig_t;

  // Data handed from cell to cell: u and v are rotated, w rides along
  typedef struct packed {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] w;
    logic                      ovf;
  } vec_t;

endpackage

`default_nettype wire

FILE: sv/euler_yxz_vertex_rotate_core.sv
// Top level of the Euler YXZ vertex rotation core: register bank and a row of rotation cells.
//
// Usage:
//   Input: raise start with x_in, y_in, z_in (signed Q16.16); the vertex is
//   taken at each rising edge where start is high and busy is low. busy is
//   low whenever reset is released, so one vertex may enter every cycle.
//   Output: done is high for exactly one cycle with x_out, y_out, z_out and
//   overflow; the result must be taken in that cycle, as the receiver
//   cannot hold it off.
//   Pipeline: one vertex per cycle sustained. Each of the three cells
//   (yaw, pitch, roll) has a product stage forming four 32x18 products
//   and a sum stage with two saturating sums.
//   Configuration: APB port, six 18-bit Q2.16 registers at byte addresses
//   0x00..0x14 (sin/cos of yaw, pitch, roll); write only while idle.
//   Reset: synchronous; sines clear to 0, cosines to 1.0, the pipeline
//   empties and busy stays high while rst is high.
`default_nettype none

module euler_yxz_vertex_rotate_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic        [eyr_pkg::ADDR_W-1:0]  paddr,
  input  wire logic        [eyr_pkg::DATA_W-1:0]  pwdata,
  output logic             [eyr_pkg::DATA_W-1:0]  prdata,
  output logic                                    pready,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [eyr_pkg::COORD_W-1:0] x_in,
  input  wire logic signed [eyr_pkg::COORD_W-1:0] y_in,
  input  wire logic signed [eyr_pkg::COORD_W-1:0] z_in,
  output logic                                    done,
  output logic signed      [eyr_pkg::COORD_W-1:0] x_out,
  output logic signed      [eyr_pkg::COORD_W-1:0] y_out,
  output logic signed      [eyr_pkg::COORD_W-1:0] z_out,
  output logic                                    overflow
);

  eyr_pkg::trig_t [eyr_pkg::NUM_CELLS-1:0] trig;
  eyr_pkg::vec_t                           link     [eyr_pkg::NUM_CELLS+1];
  logic                                    link_vld [eyr_pkg::NUM_CELLS+1];

  eyr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .trig    (trig)
  );

  // Hold off transfers only while in reset
  assign busy = rst;

  // Yaw rotates (x, z) with y riding along
  assign link_vld[0]  = start & ~busy;
  assign link[0].u    = x_in;
  assign link[0].v    = z_in;
  assign link[0].w    = y_in;
  assign link[0].ovf  = 1'b0;

  // Yaw, pitch and roll cells; each hands its neighbor the next plane
  for (genvar k = 0; k < eyr_pkg::NUM_CELLS; k++) begin : g_cell
    eyr_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (link_vld[k]),
      .in_vec  (link[k]),
      .trig    (trig[k]),
      .out_vld (link_vld[k+1]),
      .out_vec (link[k+1])
    );
  end

  // After roll the row holds (x2, z2, y2)
  assign done     = link_vld[eyr_pkg::NUM_CELLS];
  assign x_out    = link[eyr_pkg::NUM_CELLS].u;
  assign z_out    = link[eyr_pkg::NUM_CELLS].v;
  assign y_out    = link[eyr_pkg::NUM_CELLS].w;
  assign overflow = link[eyr_pkg::NUM_CELLS].ovf;

endmodule

`default_nettype wire

FILE: sv/eyr_regs.sv
// Configuration register bank holding the sine and cosine of each rotation stage.
`default_nettype none

module eyr_regs (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [eyr_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [eyr_pkg::DATA_W-1:0]    pwdata,
  output logic      [eyr_pkg::DATA_W-1:0]    prdata,
  output logic                               pready,
  output eyr_pkg::trig_t [eyr_pkg::NUM_CELLS-1:0] trig
);

  logic                                wr_en;
  eyr_pkg::reg_idx_t                   idx;
  logic signed [eyr_pkg::TRIG_W-1:0]   wdata;
  logic signed [eyr_pkg::TRIG_W-1:0]   rdata;
  eyr_pkg::trig_t [eyr_pkg::NUM_CELLS-1:0] trig_q;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = eyr_pkg::reg_idx_t'(paddr[eyr_pkg::ADDR_W-1:2]);
  assign wdata  = pwdata[eyr_pkg::TRIG_W-1:0];
  assign trig   = trig_q;

  // Write on the access cycle; indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < eyr_pkg::NUM_CELLS; i++) begin
        trig_q[i].sn <= '0;
        trig_q[i].cs <= eyr_pkg::TRIG_ONE;
      end
    end else if (wr_en) begin
      unique case (idx)
        eyr_pkg::REG_SIN_YAW:   trig_q[0].sn <= wdata;
        eyr_pkg::REG_COS_YAW:   trig_q[0].cs <= wdata;
        eyr_pkg::REG_SIN_PITCH: trig_q[1].sn <= wdata;
        eyr_pkg::REG_COS_PITCH: trig_q[1].cs <= wdata;
        eyr_pkg::REG_SIN_ROLL:  trig_q[2].sn <= wdata;
        eyr_pkg::REG_COS_ROLL:  trig_q[2].cs <= wdata;
        default: ;
      endcase
    end
  end

  // Read back, sign extended to the bus width
  always_comb begin
    unique case (idx)
      eyr_pkg::REG_SIN_YAW:   rdata = trig_q[0].sn;
      eyr_pkg::REG_COS_YAW:   rdata = trig_q[0].cs;
      eyr_pkg::REG_SIN_PITCH: rdata = trig_q[1].sn;
      eyr_pkg::REG_COS_PITCH: rdata = trig_q[1].cs;
      eyr_pkg::REG_SIN_ROLL:  rdata = trig_q[2].sn;
      eyr_pkg::REG_COS_ROLL:  rdata = trig_q[2].cs;
      default:                rdata = '0;
    endcase
  end

  assign prdata = {{(eyr_pkg::DATA_W - eyr_pkg::TRIG_W){rdata[eyr_pkg::TRIG_W-1]}}, rdata};

endmodule

`default_nettype wire

FILE: sv/eyr_cell.sv
// One plane rotation cell: four products, then two saturating sums, two register stages.
`default_nettype none

module eyr_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_vld,
  input  wire eyr_pkg::vec_t  in_vec,
  input  wire eyr_pkg::trig_t trig,
  output logic                out_vld,
  output eyr_pkg::vec_t       out_vec
);

  localparam int CW = eyr_pkg::COORD_W;
  localparam int PW = eyr_pkg::PROD_W;
  localparam int HW = eyr_pkg::SHIFT_W;
  localparam int SW = eyr_pkg::SUM_W;
  localparam int TF = eyr_pkg::TRIG_FRAC;

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Sum fits the coordinate range when all bits above the sign agree with it
  function automatic logic fits(input logic signed [SW-1:0] s);
    logic [SW-CW:0] top;
    top  = s[SW-1:CW-1];
    return (&top) | ~(|top);
  endfunction

  function automatic logic signed [CW-1:0] clamp(input logic signed [SW-1:0] s);
    logic signed [CW-1:0] r;
    if (fits(s)) r = s[CW-1:0];
    else if (s[SW-1]) r = COORD_MIN;
    else r = COORD_MAX;
    return r;
  endfunction

  logic signed [PW-1:0] p_uc, p_vs, p_vc, p_us;
  logic signed [HW-1:0] uc, vs, vc, us;
  logic signed [CW-1:0] w1;
  logic                 ovf1;
  logic                 vld1;
  logic signed [SW-1:0] sum_u, dif_v;
  logic                 vld2;
  eyr_pkg::vec_t        vec2;

  // Full products; the truncating shift is the upper part of each
  assign p_uc = in_vec.u * trig.cs;
  assign p_vs = in_vec.v * trig.sn;
  assign p_vc = in_vec.v * trig.cs;
  assign p_us = in_vec.u * trig.sn;

  // Product stage
  always_ff @(posedge clk) begin
    uc   <= p_uc[PW-1:TF];
    vs   <= p_vs[PW-1:TF];
    vc   <= p_vc[PW-1:TF];
    us   <= p_us[PW-1:TF];
    w1   <= in_vec.w;
    ovf1 <= in_vec.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
    end else begin
      vld1 <= in_vld;
      vld2 <= vld1;
    end
  end

  // u' = u*c + v*s, v' = v*c - u*s
  assign sum_u = {uc[HW-1], uc} + {vs[HW-1], vs};
  assign dif_v = {vc[HW-1], vc} - {us[HW-1], us};

  // Sum stage; hand on as (v', w, u') so the next cell rotates the next plane
  always_ff @(posedge clk) begin
    vec2.u   <= clamp(dif_v);
    vec2.v   <= w1;
    vec2.w   <= clamp(sum_u);
    vec2.ovf <= ovf1 | ~fits(sum_u) | ~fits(dif_v);
  end

  assign out_vld = vld2;
  assign out_vec = vec2;

endmodule

`default_nettype wire

FILE: sv/eyr_checker.sv
// Port-level checks for the rotation core, bound to the top level.
`default_nettype none

module eyr_props (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               pready,
  input wire logic signed [eyr_pkg::COORD_W-1:0] x_in,
  input wire logic signed [eyr_pkg::COORD_W-1:0] y_in,
  input wire logic signed [eyr_pkg::COORD_W-1:0] z_in,
  input wire logic                               done,
  input wire logic signed [eyr_pkg::COORD_W-1:0] x_out,
  input wire logic signed [eyr_pkg::COORD_W-1:0] y_out,
  input wire logic signed [eyr_pkg::COORD_W-1:0] z_out,
  input wire logic                               overflow
);

  logic xfer;
  logic zero_in;

  assign xfer    = start & ~busy;
  assign zero_in = (x_in == '0) && (y_in == '0) && (z_in == '0);

  // Every transfer yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    xfer |-> ##(eyr_pkg::LATENCY) done)
    else $error("transfer without result");

  // No result appears without a transfer the latency before
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(xfer, eyr_pkg::LATENCY))
    else $error("result without transfer");

  // Rotating the origin gives the origin, with no saturation
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done && $past(zero_in, eyr_pkg::LATENCY) |->
      (x_out == '0) && (y_out == '0) && (z_out == '0) && !overflow)
    else $error("origin not preserved");

  // Transfers are open whenever out of reset, and config never waits
  a_open: assert property (@(posedge clk) !rst |-> (!busy && pready))
    else $error("busy or pready low out of reset");

endmodule

bind euler_yxz_vertex_rotate_core eyr_props u_eyr_props (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .pready   (pready),
  .x_in     (x_in),
  .y_in     (y_in),
  .z_in     (z_in),
  .done     (done),
  .x_out    (x_out),
  .y_out    (y_out),
  .z_out    (z_out),
  .overflow (overflow)
);

`default_nettype wire

FILE: tb/eyr_checker.sv
// Checker for the Euler YXZ vertex rotation core: tracks trig registers, predicts and compares.
module eyr_checker
  import eyr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic                      pready,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] x_in,
  input  logic signed [COORD_W-1:0] y_in,
  input  logic signed [COORD_W-1:0] z_in,
  input  logic                      done,
  input  logic signed [COORD_W-1:0] x_out,
  input  logic signed [COORD_W-1:0] y_out,
  input  logic signed [COORD_W-1:0] z_out,
  input  logic                      overflow,
  output int                        pending,
  output int                        mismatches,
  output int                        vertices_checked,
  output int                        saturated_count
);

  localparam longint COORD_MAX = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      ovf;
  } vertex_t;

  logic signed [TRIG_W-1:0] trig [REG_SIN_YAW:REG_COS_ROLL];
  vertex_t                  rotated_q [$];

  // Coordinate times trig value, floored by the fraction bits
  function automatic longint scaled(input longint c, input logic signed [TRIG_W-1:0] t);
    return (c * longint'(t)) >>> TRIG_FRAC;
  endfunction

  // Clamp a stage output to the coordinate range and flag it
  function automatic longint clamp_coord(input longint v, inout logic ovf);
    if (v > COORD_MAX) begin
      ovf = 1'b1;
      return COORD_MAX;
    end
    if (v < COORD_MIN) begin
      ovf = 1'b1;
      return COORD_MIN;
    end
    return v;
  endfunction

  // Yaw about Y, then pitch about X, then roll about Z
  function automatic vertex_t rotate_vertex(input logic signed [COORD_W-1:0] xi,
                                            input logic signed [COORD_W-1:0] yi,
                                            input logic signed [COORD_W-1:0] zi);
    longint  x, y, z, t;
    logic    ovf;
    vertex_t r;
    x = longint'(xi);
    y = longint'(yi);
    z = longint'(zi);
    ovf = 1'b0;
    t = clamp_coord(scaled(x, trig[REG_COS_YAW]) + scaled(z, trig[REG_SIN_YAW]), ovf);
    z = clamp_coord(scaled(z, trig[REG_COS_YAW]) - scaled(x, trig[REG_SIN_YAW]), ovf);
    x = t;
    t = clamp_coord(scaled(y, trig[REG_COS_PITCH]) - scaled(z, trig[REG_SIN_PITCH]), ovf);
    z = clamp_coord(scaled(z, trig[REG_COS_PITCH]) + scaled(y, trig[REG_SIN_PITCH]), ovf);
    y = t;
    t = clamp_coord(scaled(x, trig[REG_COS_ROLL]) - scaled(y, trig[REG_SIN_ROLL]), ovf);
    y = clamp_coord(scaled(y, trig[REG_COS_ROLL]) + scaled(x, trig[REG_SIN_ROLL]), ovf);
    x = t;
    r.x = x[COORD_W-1:0];
    r.y = y[COORD_W-1:0];
    r.z = z[COORD_W-1:0];
    r.ovf = ovf;
    return r;
  endfunction

  initial begin
    pending = 0;
    mismatches = 0;
    vertices_checked = 0;
    saturated_count = 0;
  end

  // Watch config writes, input transfers and result strobes
  always @(posedge clk) begin
    logic [ADDR_W-3:0] idx;
    vertex_t           got, want;
    if (rst) begin
      trig[REG_SIN_YAW]   = '0;
      trig[REG_COS_YAW]   = TRIG_ONE;
      trig[REG_SIN_PITCH] = '0;
      trig[REG_COS_PITCH] = TRIG_ONE;
      trig[REG_SIN_ROLL]  = '0;
      trig[REG_COS_ROLL]  = TRIG_ONE;
      rotated_q.delete();
    end else begin
      // Update the register copy; writes past the last register are dropped
      if (psel && penable && pwrite && pready) begin
        idx = paddr[ADDR_W-1:2];
        if (idx <= REG_COS_ROLL)
          trig[reg_idx_t'(idx)] = pwdata[TRIG_W-1:0];
      end
      // Compare each result with the oldest prediction
      if (done) begin
        got = '{x: x_out, y: y_out, z: z_out, ovf: overflow};
        if (rotated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result x=%h y=%h z=%h ovf=%b",
                     got.x, got.y, got.z, got.ovf);
        end else begin
          want = rotated_q.pop_front();
          vertices_checked++;
          if (want.ovf) saturated_count++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected x=%h y=%h z=%h ovf=%b, got x=%h y=%h z=%h ovf=%b",
                       want.x, want.y, want.z, want.ovf, got.x, got.y, got.z, got.ovf);
          end
        end
      end
      // Predict the rotated vertex for each transfer
      if (start && !busy)
        rotated_q.push_back(rotate_vertex(x_in, y_in, z_in));
    end
    pending = rotated_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the testbench: clock, reset, stimulus for the rotation core, and the verdict.
module testbench;
  import eyr_pkg::*;

  localparam int TRIG_MAX_I  = 131071;
  localparam int TRIG_MIN_I  = -131072;
  localparam int TRIG_ONE_I  = 65536;
  localparam int N_SETTINGS  = 9;
  localparam int PER_SETTING = 105;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ADDR_W-1:0]         paddr = '0;
  logic [DATA_W-1:0]         pwdata = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] x_in = '0;
  logic signed [COORD_W-1:0] y_in = '0;
  logic signed [COORD_W-1:0] z_in = '0;
  logic                      done;
  logic signed [COORD_W-1:0] x_out, y_out, z_out;
  logic                      overflow;

  int pending, mismatches, vertices_checked, saturated_count;
  int cycles = 0;
  int send_idle_pct = 0;
  int settings_used = 0;
  int trig_set [REG_SIN_YAW:REG_COS_ROLL];

  euler_yxz_vertex_rotate_core u_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .x_in, .y_in, .z_in, .done, .x_out, .y_out, .z_out, .overflow
  );

  eyr_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .start, .busy, .x_in, .y_in, .z_in, .done, .x_out, .y_out, .z_out, .overflow,
    .pending, .mismatches, .vertices_checked, .saturated_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // One register write: setup cycle, access cycle, then release the bus
  task automatic apb_write(input int idx, input int value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Drain the pipeline, then load trig_set plus two writes past the last register
  task automatic program_trig();
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 2) @(negedge clk);
    for (int i = REG_SIN_YAW; i <= REG_COS_ROLL; i++)
      apb_write(i, trig_set[i]);
    apb_write(int'(REG_COS_ROLL) + 1, $urandom);
    apb_write(int'(REG_COS_ROLL) + 2, $urandom);
    settings_used++;
  endtask

  // Offer one vertex, with random idle cycles ahead of it; hold until transfer
  task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      start <= 1'b0;
      x_in <= $urandom;
      y_in <= $urandom;
      z_in <= $urandom;
      @(negedge clk);
    end
    start <= 1'b1;
    x_in <= x;
    y_in <= y;
    z_in <= z;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] rand_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 8) return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic int rand_trig_extreme();
    case ($urandom_range(0, 4))
      0: return TRIG_MAX_I;
      1: return TRIG_MIN_I;
      2: return TRIG_ONE_I;
      3: return -TRIG_ONE_I;
      default: return 0;
    endcase
  endfunction

  // Fill trig_set for one setting of the given kind
  task automatic pick_trig(input int kind);
    real ang;
    for (int g = 0; g < 3; g++) begin
      case (kind)
        0: begin
          ang = $urandom_range(0, 35999) * 6.283185307179586 / 36000.0;
          trig_set[2*g]   = int'($sin(ang) * TRIG_ONE_I);
          trig_set[2*g+1] = int'($cos(ang) * TRIG_ONE_I);
        end
        1: begin
          case ($urandom_range(0, 3))
            0: begin trig_set[2*g] = 0;           trig_set[2*g+1] = TRIG_ONE_I;  end
            1: begin trig_set[2*g] = TRIG_ONE_I;  trig_set[2*g+1] = 0;           end
            2: begin trig_set[2*g] = 0;           trig_set[2*g+1] = -TRIG_ONE_I; end
            default: begin trig_set[2*g] = -TRIG_ONE_I; trig_set[2*g+1] = 0;     end
          endcase
        end
        2: begin
          trig_set[2*g]   = $urandom_range(0, 262143) - 131072;
          trig_set[2*g+1] = $urandom_range(0, 262143) - 131072;
        end
        default: begin
          trig_set[2*g]   = rand_trig_extreme();
          trig_set[2*g+1] = rand_trig_extreme();
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes through the reset identity rotation
    send_idle_pct = 33;
    send_vertex('0, '0, '0);
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(C_MAX, C_MIN, '0);
    send_vertex(-1, -1, -1);
    send_vertex(1, 1, 1);
    send_vertex(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000);
    send_vertex(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0);

    // Directed: trig values at the top of the 18-bit range, saturating stages
    foreach (trig_set[i]) trig_set[i] = TRIG_MAX_I;
    program_trig();
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(C_MAX, C_MIN, C_MAX);
    send_vertex(1, 0, -1);
    send_vertex(-1, -1, -1);

    // Directed: trig values at the bottom of the range
    foreach (trig_set[i]) trig_set[i] = TRIG_MIN_I;
    program_trig();
    send_vertex(C_MIN, C_MIN, C_MIN);
    send_vertex(C_MAX, C_MAX, C_MAX);
    send_vertex(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);

    // Directed: quarter turns on every axis
    trig_set[REG_SIN_YAW]   = TRIG_ONE_I;  trig_set[REG_COS_YAW]   = 0;
    trig_set[REG_SIN_PITCH] = -TRIG_ONE_I; trig_set[REG_COS_PITCH] = 0;
    trig_set[REG_SIN_ROLL]  = TRIG_ONE_I;  trig_set[REG_COS_ROLL]  = 0;
    program_trig();
    send_vertex(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
    send_vertex(C_MIN, C_MAX, C_MIN);
    send_vertex(C_MAX, '0, C_MIN);

    // Random settings, sender gaps at 33, then 49, then none in a hundred
    for (int s = 0; s < N_SETTINGS; s++) begin
      send_idle_pct = (s < 3) ? 33 : (s < 6) ? 49 : 0;
      pick_trig(s % 4);
      program_trig();
      for (int n = 0; n < PER_SETTING; n++)
        send_vertex(rand_coord(), rand_coord(), rand_coord());
    end

    // Drain and give the verdict
    start <= 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 4) @(negedge clk);
    $display("rotated %0d vertices under %0d trig settings, %0d with saturation",
             vertices_checked, settings_used, saturated_count);
    $display("%0d mismatches, %0d cycles", mismatches, cycles);
    if (mismatches == 0 && pending == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
